### rtl/core/lss_pkg.sv
// Shared constants and types for the least-squares slope block.
package lss_pkg;

   localparam int MaxSamples = 256;
   localparam int AddrWidth  = $clog2(MaxSamples);
   localparam int CountWidth = AddrWidth + 1;
   localparam int DataWidth  = 32;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO_DIV = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // Work request from the front end to the back end.
   typedef struct packed {
      logic [1:0]            status;
      logic [CountWidth-1:0] count;
      logic [DataWidth-1:0]  value_sum;
   } job_type;

endpackage

### rtl/core/lss_front.sv
// Front end: scales, stores and sums samples; posts a job on the last sample.
module lss_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [31:0]                   multiplier,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [31:0]            req_sample,
   input  logic                          req_last,
   input  logic                          back_busy,
   output logic                          wr_en,
   output logic [lss_pkg::AddrWidth-1:0] wr_addr,
   output logic [31:0]                   wr_data,
   output logic                          job_valid,
   output lss_pkg::job_type              job,
   input  logic                          job_full
);

   logic [lss_pkg::CountWidth-1:0] count_ff, count_in;
   logic [31:0]                    sum_ff, sum_in;
   logic                           ovf_ff, ovf_in;
   logic                           wait_ff, wait_in;
   logic                           accept;
   logic                           room;
   logic [31:0]                    scaled;
   logic [lss_pkg::CountWidth-1:0] count_next;
   logic [31:0]                    sum_next;
   logic                           ovf_next;

   // The store is shared with the back end, so hold off while a set is in flight.
   assign req_stall = wait_ff || back_busy || job_full;
   assign accept    = req_valid && !req_stall;
   assign room      = count_ff < lss_pkg::CountWidth'(lss_pkg::MaxSamples);
   assign scaled    = 32'(req_sample * $signed(multiplier));

   assign wr_en   = accept && room;
   assign wr_addr = count_ff[lss_pkg::AddrWidth-1:0];
   assign wr_data = scaled;

   always_comb begin
      count_next = room ? count_ff + 1'b1 : count_ff;
      sum_next   = room ? sum_ff + scaled : sum_ff;
      ovf_next   = ovf_ff || !room;
      job_valid  = accept && req_last;
      job.count     = count_next;
      job.value_sum = sum_next;
      if (ovf_next) begin
         job.status = lss_pkg::STATUS_OVERFLOW;
      end else if (count_next < lss_pkg::CountWidth'(2)) begin
         job.status = lss_pkg::STATUS_ZERO_DIV;
      end else begin
         job.status = lss_pkg::STATUS_OK;
      end
      count_in = count_ff;
      sum_in   = sum_ff;
      ovf_in   = ovf_ff;
      wait_in  = wait_ff && !back_busy ? 1'b0 : wait_ff;
      if (accept) begin
         if (req_last) begin
            count_in = '0;
            sum_in   = '0;
            ovf_in   = 1'b0;
            wait_in  = 1'b1;
         end else begin
            count_in = count_next;
            sum_in   = sum_next;
            ovf_in   = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
         wait_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         ovf_ff   <= ovf_in;
         // Hold the stall until the back end has picked up the job and is no longer busy.
         wait_ff  <= wait_in;
      end
   end

endmodule

### rtl/core/lss_queue.sv
// Small job queue between front and back ends.
module lss_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lss_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output lss_pkg::job_type head
);

   lss_pkg::job_type             slot_ff [lss_pkg::QueueDepth];
   logic [lss_pkg::QueuePtrW-1:0] wp_ff, rp_ff;
   logic [lss_pkg::QueuePtrW:0]   fill_ff;

   assign full      = fill_ff == (lss_pkg::QueuePtrW+1)'(lss_pkg::QueueDepth);
   assign not_empty = fill_ff != '0;
   assign head      = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         fill_ff <= fill_ff + (lss_pkg::QueuePtrW+1)'(push) - (lss_pkg::QueuePtrW+1)'(pop);
      end
   end

endmodule

### rtl/core/lss_div.sv
// Radix-2 signed divider, truncating toward zero, one bit per cycle.
module lss_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [31:0] rem_ff, quo_ff, den_ff;
   logic        neg_ff, busy_ff;
   logic [5:0]  cnt_ff;
   logic [32:0] trial;
   logic [31:0] shifted;

   assign shifted = {rem_ff[30:0], quo_ff[31]};
   assign trial   = {1'b0, shifted} - {1'b0, den_ff};
   assign quotient = neg_ff ? 32'(0) - quo_ff : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd32;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend[31] ? 32'(0) - dividend : dividend;
         den_ff <= divisor[31] ? 32'(0) - divisor : divisor;
         neg_ff <= dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= shifted;
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

endmodule

### rtl/core/lss_back.sv
// Back end: means, second pass over the store, slope division.
module lss_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_ready,
   input  lss_pkg::job_type              job,
   output logic                          job_pop,
   output logic                          busy,
   output logic [lss_pkg::AddrWidth-1:0] rd_addr,
   output logic                          rd_en,
   input  logic [31:0]                   rd_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_slope,
   output logic [1:0]                    rsp_status
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_XDIV  = 4'd1;
   localparam logic [3:0] ST_XWAIT = 4'd2;
   localparam logic [3:0] ST_YDIV  = 4'd3;
   localparam logic [3:0] ST_YWAIT = 4'd4;
   localparam logic [3:0] ST_SCAN  = 4'd5;
   localparam logic [3:0] ST_DRAIN = 4'd6;
   localparam logic [3:0] ST_SDIV  = 4'd7;
   localparam logic [3:0] ST_SWAIT = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;

   logic [3:0]  state_ff;
   logic [lss_pkg::CountWidth-1:0] n_ff, idx_ff;
   logic [31:0] ysum_ff, xm_ff, ym_ff, sxy_ff, sxx_ff;
   logic [31:0] dx_ff, dy_ff, pxy_ff, pxx_ff;
   logic        rv_ff, dv_ff, pv_ff;
   logic [31:0] x_ff;
   logic [31:0] sumx_ff;
   logic        dstart;
   logic [31:0] dnum, dden, dq;
   logic        ddone;
   logic [31:0] nn;

   lss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dstart),
      .dividend (dnum),
      .divisor  (dden),
      .done     (ddone),
      .quotient (dq)
   );

   assign nn      = 32'(n_ff);
   assign busy    = state_ff != ST_IDLE || job_ready;
   assign job_pop = state_ff == ST_IDLE && job_ready;
   assign rd_en   = state_ff == ST_SCAN;
   assign rd_addr = idx_ff[lss_pkg::AddrWidth-1:0];

   always_comb begin
      dstart = 1'b0;
      dnum   = sumx_ff;
      dden   = nn;
      unique case (state_ff)
         ST_XDIV: begin
            dstart = 1'b1;
            dnum   = sumx_ff;
         end
         ST_YDIV: begin
            dstart = 1'b1;
            dnum   = ysum_ff;
         end
         ST_SDIV: begin
            dstart = 1'b1;
            dnum   = sxy_ff;
            dden   = sxx_ff;
         end
         default: begin
            dstart = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rsp_valid <= 1'b0;
         rv_ff     <= 1'b0;
         dv_ff     <= 1'b0;
         pv_ff     <= 1'b0;
      end else begin
         rv_ff <= state_ff == ST_SCAN;
         dv_ff <= rv_ff;
         pv_ff <= dv_ff;
         unique case (state_ff)
            ST_IDLE: begin
               if (job_ready) begin
                  n_ff    <= job.count;
                  ysum_ff <= job.value_sum;
                  // sum of x = n(n-1)/2, product fits in 32 bits at these depths
                  sumx_ff <= 32'((32'(job.count) * 32'(job.count - 1'b1)) >> 1);
                  if (job.status != lss_pkg::STATUS_OK) begin
                     rsp_slope  <= '0;
                     rsp_status <= job.status;
                     rsp_valid  <= 1'b1;
                     state_ff   <= ST_OUT;
                  end else begin
                     state_ff <= ST_XDIV;
                  end
               end
            end
            ST_XDIV:  state_ff <= ST_XWAIT;
            ST_XWAIT: if (ddone) begin
               xm_ff    <= dq;
               state_ff <= ST_YDIV;
            end
            ST_YDIV:  state_ff <= ST_YWAIT;
            ST_YWAIT: if (ddone) begin
               ym_ff    <= dq;
               idx_ff   <= '0;
               sxy_ff   <= '0;
               sxx_ff   <= '0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == n_ff - 1'b1) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               if (!rv_ff && !dv_ff && !pv_ff) begin
                  if (sxx_ff == '0) begin
                     rsp_slope  <= '0;
                     rsp_status <= lss_pkg::STATUS_ZERO_DIV;
                     rsp_valid  <= 1'b1;
                     state_ff   <= ST_OUT;
                  end else begin
                     state_ff <= ST_SDIV;
                  end
               end
            end
            ST_SDIV:  state_ff <= ST_SWAIT;
            ST_SWAIT: if (ddone) begin
               rsp_slope  <= dq;
               rsp_status <= lss_pkg::STATUS_OK;
               rsp_valid  <= 1'b1;
               state_ff   <= ST_OUT;
            end
            ST_OUT: if (!rsp_stall) begin
               rsp_valid <= 1'b0;
               state_ff  <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (pv_ff) begin
            sxy_ff <= sxy_ff + pxy_ff;
            sxx_ff <= sxx_ff + pxx_ff;
         end
      end
   end

   // Scan pipeline: read, difference, multiply, accumulate.
   always_ff @(posedge clock) begin
      if (state_ff == ST_SCAN) x_ff <= 32'(idx_ff) - xm_ff;
      dx_ff  <= x_ff;
      dy_ff  <= rd_data - ym_ff;
      pxy_ff <= 32'(dx_ff * dy_ff);
      pxx_ff <= 32'(dx_ff * dx_ff);
   end

endmodule

### rtl/core/least_squares_slope.sv
// Top level of the least-squares slope block.
//  channel  | handshake            | payload
//  req      | req_valid/req_stall  | req_sample, req_last
//  rsp      | rsp_valid/rsp_stall  | rsp_slope, rsp_status
//  csr      | csr_write            | csr_data (multiplier)
// Each accepted sample is written into the 256-entry store while there is room.
// A last sample starts the back end: two divisions for the means, a pass over the store
// and a drain of the scan pipeline, and the slope division, unless an error status ends it early.
// The input stalls while a set is being worked out or its result waits.
// Reset sets the multiplier to 1 and empties the set; the store needs no clearing.
module least_squares_slope (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic signed [31:0] csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_sample,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_slope,
   output logic [1:0]         rsp_status
);

   logic [31:0]                    mult_ff;
   logic                           wr_en, rd_en, back_busy;
   logic [lss_pkg::AddrWidth-1:0]  wr_addr, rd_addr;
   logic [31:0]                    wr_data, rd_data_ff;
   logic [31:0]                    store [lss_pkg::MaxSamples];
   logic                           job_valid, job_full, job_pop, job_ready;
   lss_pkg::job_type               job_in, job_head;

   always_ff @(posedge clock) begin
      if (reset) mult_ff <= 32'd1;
      else if (csr_write) mult_ff <= csr_data;
   end

   always_ff @(posedge clock) begin
      if (wr_en) store[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= store[rd_addr];
   end

   lss_front u_front (
      .clock (clock), .reset (reset), .multiplier (mult_ff),
      .req_valid (req_valid), .req_stall (req_stall),
      .req_sample (req_sample), .req_last (req_last),
      .back_busy (back_busy),
      .wr_en (wr_en), .wr_addr (wr_addr), .wr_data (wr_data),
      .job_valid (job_valid), .job (job_in), .job_full (job_full)
   );

   lss_queue u_queue (
      .clock (clock), .reset (reset),
      .push (job_valid), .push_job (job_in), .full (job_full),
      .pop (job_pop), .not_empty (job_ready), .head (job_head)
   );

   lss_back u_back (
      .clock (clock), .reset (reset),
      .job_ready (job_ready), .job (job_head), .job_pop (job_pop),
      .busy (back_busy), .rd_addr (rd_addr), .rd_en (rd_en),
      .rd_data (rd_data_ff),
      .rsp_valid (rsp_valid), .rsp_stall (rsp_stall),
      .rsp_slope (rsp_slope), .rsp_status (rsp_status)
   );

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      back_busy |-> req_stall) else $error("sample taken while back end busy");
   a_pop_has_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_ready) else $error("pop from empty queue");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3)) else $error("bad status");

endmodule
